@@ hdl/ranging_timing_budget_calc_core_defines.svh @@
// assertion macros shared by the timing budget calculator modules
`ifndef RANGING_TIMING_BUDGET_CALC_CORE_DEFINES_SVH
`define RANGING_TIMING_BUDGET_CALC_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define RTBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define RTBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rtbc_pkg.sv @@
// types, constants and decode helpers of the timing budget calculator
`timescale 1ns / 1ps
`default_nettype none

package rtbc_pkg;

  // operand widths of the serial arithmetic unit
  localparam int ALU_A_W = 32;
  localparam int ALU_B_W = 10;
  localparam int ALU_CNT_W = $clog2(ALU_A_W);

  // timing constants, microseconds unless noted
  localparam logic [15:0] START_OVH     = 16'd1910;
  localparam logic [15:0] SET_START_OVH = 16'd1320;
  localparam logic [15:0] END_OVH       = 16'd960;
  localparam logic [15:0] MSRC_OVH      = 16'd660;
  localparam logic [15:0] TCC_OVH       = 16'd590;
  localparam logic [15:0] DSS_OVH       = 16'd690;
  localparam logic [15:0] PRE_OVH       = 16'd660;
  localparam logic [15:0] FINAL_OVH     = 16'd550;
  localparam logic [31:0] MIN_BUDGET_US = 32'd20000;
  localparam logic [ALU_B_W-1:0] NS_PER_US = 10'd1000;
  localparam logic [31:0] HALF_US_NS    = 32'd500;
  localparam logic [19:0] PERIOD_NS_MUL = 20'd2304;
  localparam logic [19:0] PERIOD_NS_OFS = 20'd1655;

  // input item
  typedef struct packed {
    logic [7:0]  step_enables;
    logic [7:0]  pre_period_code;
    logic [7:0]  final_period_code;
    logic [7:0]  short_timeout_code;
    logic [15:0] pre_timeout_word;
    logic [15:0] final_timeout_word;
    logic [31:0] requested_budget_us;
  } rtbc_in_t;

  // result item
  typedef struct packed {
    logic [31:0] current_budget_us;
    logic [15:0] new_final_word;
    logic        request_accepted;
    logic        word_valid;
  } rtbc_out_t;

  // serial unit operations
  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic                start;
    alu_op_t             op;
    logic [ALU_A_W-1:0]  a;
    logic [ALU_B_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic [ALU_A_W-1:0] result;
  } alu_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] value;
  } norm_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] word;
  } norm_rsp_t;

  // pulse period from its code, ((code+1)*2) mod 256
  function automatic logic [7:0] period_of(input logic [7:0] code);
    logic [7:0] inc;
    inc = code + 8'd1;
    return {inc[6:0], 1'b0};
  endfunction

  // numerator of the macro period in ns, 2304*period+1655
  function automatic logic [19:0] macro_num(input logic [7:0] period);
    return (PERIOD_NS_MUL * {12'd0, period}) + PERIOD_NS_OFS;
  endfunction

  // exponent/mantissa timeout to macro clocks, low 16 bits kept
  function automatic logic [15:0] mclks_of(input logic [15:0] word);
    logic [15:0] prod;
    prod = (word[15:12] == 4'd0) ? ({8'd0, word[7:0]} << word[11:8]) : 16'd0;
    return prod + 16'd1;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rtbc_alu.sv @@
// shared serial unit: shift-add multiply and restoring divide, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
`include "ranging_timing_budget_calc_core_defines.svh"

module rtbc_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  rtbc_pkg::alu_req_t alu_req,
  output rtbc_pkg::alu_rsp_t alu_rsp
);
  import rtbc_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [ALU_CNT_W-1:0] cnt_r;
  alu_op_t              op_r;
  logic [ALU_A_W-1:0]   acc_r;
  logic [ALU_A_W-1:0]   sh_r;
  logic [ALU_B_W-1:0]   b_r;
  logic [ALU_B_W-1:0]   mplr_r;
  logic [ALU_B_W-1:0]   rem_r;
  logic [ALU_B_W:0]     trial;
  logic [ALU_B_W:0]     rem_sub;
  logic                 fits;

  // divide step: bring down the next dividend bit and try the divisor
  assign trial   = {rem_r, sh_r[ALU_A_W-1]};
  assign fits    = trial >= {1'b0, b_r};
  assign rem_sub = trial - {1'b0, b_r};

  // step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (alu_req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (alu_req.op == ALU_MUL) ? ALU_CNT_W'(ALU_B_W - 1)
                                           : ALU_CNT_W'(ALU_A_W - 1);
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // operand shift registers
  always_ff @(posedge clk) begin
    if (alu_req.start) begin
      op_r   <= alu_req.op;
      acc_r  <= '0;
      sh_r   <= alu_req.a;
      b_r    <= alu_req.b;
      mplr_r <= alu_req.b;
      rem_r  <= '0;
    end else if (busy_r) begin
      case (op_r)
        ALU_MUL: begin
          if (mplr_r[0]) begin
            acc_r <= acc_r + sh_r;
          end
          sh_r   <= sh_r << 1;
          mplr_r <= mplr_r >> 1;
        end
        ALU_DIV: begin
          sh_r  <= sh_r << 1;
          acc_r <= {acc_r[ALU_A_W-2:0], fits};
          rem_r <= fits ? rem_sub[ALU_B_W-1:0] : trial[ALU_B_W-1:0];
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
  end

  assign alu_rsp.done   = done_r;
  assign alu_rsp.result = acc_r;

  `RTBC_ASSERT_IMPL(a_no_restart, clk, rst_n, alu_req.start, !busy_r, "alu started while busy")
  `RTBC_ASSERT_IMPL(a_rem_bound, clk, rst_n, busy_r && (op_r == ALU_DIV), rem_r < b_r, "remainder not below divisor")
  `RTBC_ASSERT_IMPL(a_done_on_end, clk, rst_n, $fell(busy_r), done_r, "alu ended without done")

endmodule

`default_nettype wire

@@ hdl/rtbc_norm.sv @@
// serial normalizer: encodes macro clocks as exponent and 8-bit mantissa
`timescale 1ns / 1ps
`default_nettype none

module rtbc_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  rtbc_pkg::norm_req_t norm_req,
  output rtbc_pkg::norm_rsp_t norm_rsp
);
  import rtbc_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic        zero_r;
  logic [31:0] low_r;
  logic [4:0]  high_r;
  logic        settled;

  // mantissa fits in a byte, or nothing to encode
  assign settled = zero_r || (low_r[31:8] == 24'd0);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (norm_req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && settled) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // one right shift per cycle, counting the exponent
  always_ff @(posedge clk) begin
    if (norm_req.start) begin
      low_r  <= norm_req.value - 32'd1;
      high_r <= '0;
      zero_r <= (norm_req.value == 32'd0);
    end else if (busy_r && !settled) begin
      low_r  <= low_r >> 1;
      high_r <= high_r + 5'd1;
    end
  end

  assign norm_rsp.done = done_r;
  assign norm_rsp.word = zero_r ? 16'd0 : {3'd0, high_r, low_r[7:0]};

endmodule

`default_nettype wire

@@ hdl/ranging_timing_budget_calc_core.sv @@
// top level: sequencer around the serial unit and the normalizer
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready   | rtbc_in_t  (timing words, request)
//  out_    | output    | out_valid/out_ready | rtbc_out_t (budget, new word, flags)
//
// One item at a time; the shared one-bit-per-cycle unit does every multiply and
// divide of an item, and the normalizer runs only when a new final-range word
// is encoded.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
// A result waits in the output register; the next item is taken meanwhile,
// and a finished item stalls in its last state only while that register is full.
`timescale 1ns / 1ps
`default_nettype none
`include "ranging_timing_budget_calc_core_defines.svh"

module ranging_timing_budget_calc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rtbc_pkg::rtbc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rtbc_pkg::rtbc_out_t out_data
);
  import rtbc_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_ISSUE    = 8'b0000_0010,
    ST_WAIT     = 8'b0000_0100,
    ST_SUM      = 8'b0000_1000,
    ST_CHECK    = 8'b0001_0000,
    ST_ENC_GO   = 8'b0010_0000,
    ST_ENC_WAIT = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  typedef enum logic [3:0] {
    STEP_MNS_PRE   = 4'd0,
    STEP_MNS_FIN   = 4'd1,
    STEP_SHORT_MUL = 4'd2,
    STEP_SHORT_DIV = 4'd3,
    STEP_PRE_MUL   = 4'd4,
    STEP_PRE_DIV   = 4'd5,
    STEP_FIN_MUL   = 4'd6,
    STEP_FIN_DIV   = 4'd7,
    STEP_REM_MUL   = 4'd8,
    STEP_REM_DIV   = 4'd9
  } step_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;
  norm_req_t norm_req;
  norm_rsp_t norm_rsp;

  // decoded item
  logic        tcc_r, dss_r, msrc_r, pre_r, fin_r;
  logic [7:0]  pre_p_r, fin_p_r;
  logic [8:0]  short_mclks_r;
  logic [15:0] pre_mclks_r, fin_mclks_r;
  logic [31:0] req_r;

  // intermediate results
  logic [ALU_B_W-1:0] mpre_r, mfin_r;
  logic [7:0]  short_us_r;
  logic [15:0] pre_us_r, fin_us_r;
  logic [15:0] steps_r;
  logic [16:0] cur_r;
  logic [16:0] lim_r;
  logic        acc_r, wvalid_r;
  logic [15:0] word_r;

  logic        out_valid_r;
  rtbc_out_t   out_data_r;

  logic        in_fire;
  logic        out_load;
  logic [15:0] pre_mclks_in, fin_mclks_in;
  logic [15:0] t_tcc, t_ds, t_pre;
  logic [16:0] cur_c, lim_c, t_fin;
  logic        req_ok, req_fits, need_word;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // timeout decode at acceptance
  assign pre_mclks_in = mclks_of(in_data.pre_timeout_word);
  assign fin_mclks_in = in_data.step_enables[6]
                        ? mclks_of(in_data.final_timeout_word) - pre_mclks_in
                        : mclks_of(in_data.final_timeout_word);

  // per-step overheads
  assign t_tcc = tcc_r ? (16'(short_us_r) + TCC_OVH) : 16'd0;
  assign t_ds  = dss_r  ? ((16'(short_us_r) + DSS_OVH) << 1)
               : msrc_r ? (16'(short_us_r) + MSRC_OVH) : 16'd0;
  assign t_pre = pre_r ? (pre_us_r + PRE_OVH) : 16'd0;

  // budget totals and request check
  assign t_fin     = fin_r ? (17'(fin_us_r) + 17'(FINAL_OVH)) : 17'd0;
  assign cur_c     = 17'(steps_r) + 17'(START_OVH + END_OVH) + t_fin;
  assign lim_c     = 17'(steps_r) + 17'(SET_START_OVH + END_OVH + FINAL_OVH);
  assign req_ok    = (req_r >= MIN_BUDGET_US);
  assign req_fits  = (req_r > {15'd0, lim_c});
  assign need_word = req_ok && fin_r && req_fits;

  // operand selection for the serial unit
  always_comb begin
    alu_req       = '0;
    alu_req.start = (state_r == ST_ISSUE);
    case (step_r)
      STEP_MNS_PRE: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = {12'd0, macro_num(pre_p_r)};
        alu_req.b  = NS_PER_US;
      end
      STEP_MNS_FIN: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = {12'd0, macro_num(fin_p_r)};
        alu_req.b  = NS_PER_US;
      end
      STEP_SHORT_MUL: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = {23'd0, short_mclks_r};
        alu_req.b  = mpre_r;
      end
      STEP_PRE_MUL: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = {16'd0, pre_mclks_r};
        alu_req.b  = mpre_r;
      end
      STEP_FIN_MUL: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = {16'd0, fin_mclks_r};
        alu_req.b  = mfin_r;
      end
      STEP_SHORT_DIV, STEP_PRE_DIV, STEP_FIN_DIV: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = alu_rsp.result + HALF_US_NS;
        alu_req.b  = NS_PER_US;
      end
      STEP_REM_MUL: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = req_r - {15'd0, lim_r};
        alu_req.b  = NS_PER_US;
      end
      STEP_REM_DIV: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = alu_rsp.result + {22'd0, (mfin_r >> 1)};
        alu_req.b  = mfin_r;
      end
      default: begin
        alu_req.op = ALU_MUL;
      end
    endcase
  end

  // normalizer gets the quotient plus the pre-range clocks when that step is enabled
  assign norm_req.start = (state_r == ST_ENC_GO);
  assign norm_req.value = alu_rsp.result + (pre_r ? {16'd0, pre_mclks_r} : 32'd0);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_ISSUE;
          step_nxt  = STEP_MNS_PRE;
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (alu_rsp.done) begin
          case (step_r)
            STEP_MNS_PRE:   begin step_nxt = STEP_MNS_FIN;   state_nxt = ST_ISSUE; end
            STEP_MNS_FIN:   begin step_nxt = STEP_SHORT_MUL; state_nxt = ST_ISSUE; end
            STEP_SHORT_MUL: begin step_nxt = STEP_SHORT_DIV; state_nxt = ST_ISSUE; end
            STEP_SHORT_DIV: begin step_nxt = STEP_PRE_MUL;   state_nxt = ST_ISSUE; end
            STEP_PRE_MUL:   begin step_nxt = STEP_PRE_DIV;   state_nxt = ST_ISSUE; end
            STEP_PRE_DIV:   begin step_nxt = STEP_FIN_MUL;   state_nxt = ST_ISSUE; end
            STEP_FIN_MUL:   begin step_nxt = STEP_FIN_DIV;   state_nxt = ST_ISSUE; end
            STEP_FIN_DIV:   begin state_nxt = ST_SUM; end
            STEP_REM_MUL:   begin step_nxt = STEP_REM_DIV;   state_nxt = ST_ISSUE; end
            STEP_REM_DIV:   begin state_nxt = ST_ENC_GO; end
            default:        begin state_nxt = ST_IDLE; end
          endcase
        end
      end
      ST_SUM: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (need_word) begin
          state_nxt = ST_ISSUE;
          step_nxt  = STEP_REM_MUL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_ENC_GO: begin
        state_nxt = ST_ENC_WAIT;
      end
      ST_ENC_WAIT: begin
        if (norm_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_MNS_PRE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item capture and intermediate results
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tcc_r         <= in_data.step_enables[4];
      dss_r         <= in_data.step_enables[3];
      msrc_r        <= in_data.step_enables[2];
      pre_r         <= in_data.step_enables[6];
      fin_r         <= in_data.step_enables[7];
      pre_p_r       <= period_of(in_data.pre_period_code);
      fin_p_r       <= period_of(in_data.final_period_code);
      short_mclks_r <= {1'b0, in_data.short_timeout_code} + 9'd1;
      pre_mclks_r   <= pre_mclks_in;
      fin_mclks_r   <= fin_mclks_in;
      req_r         <= in_data.requested_budget_us;
    end
    if ((state_r == ST_WAIT) && alu_rsp.done) begin
      case (step_r)
        STEP_MNS_PRE:   mpre_r     <= alu_rsp.result[ALU_B_W-1:0];
        STEP_MNS_FIN:   mfin_r     <= alu_rsp.result[ALU_B_W-1:0];
        STEP_SHORT_DIV: short_us_r <= alu_rsp.result[7:0];
        STEP_PRE_DIV:   pre_us_r   <= alu_rsp.result[15:0];
        STEP_FIN_DIV:   fin_us_r   <= alu_rsp.result[15:0];
        default:        mpre_r     <= mpre_r;
      endcase
    end
    if (state_r == ST_SUM) begin
      steps_r <= t_tcc + t_ds + t_pre;
    end
    if (state_r == ST_CHECK) begin
      cur_r    <= cur_c;
      lim_r    <= lim_c;
      acc_r    <= req_ok && (!fin_r || req_fits);
      wvalid_r <= need_word;
      word_r   <= 16'd0;
    end
    if ((state_r == ST_ENC_WAIT) && norm_rsp.done) begin
      word_r <= norm_rsp.word;
    end
    if (out_load) begin
      out_data_r.current_budget_us <= {15'd0, cur_r};
      out_data_r.new_final_word    <= word_r;
      out_data_r.request_accepted  <= acc_r;
      out_data_r.word_valid        <= wvalid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rtbc_alu u_alu (
    .clk     (clk),
    .rst_n   (rst_n),
    .alu_req (alu_req),
    .alu_rsp (alu_rsp)
  );

  rtbc_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .norm_req (norm_req),
    .norm_rsp (norm_rsp)
  );

  `RTBC_ASSERT_IMPL(a_alu_done_in_wait, clk, rst_n, alu_rsp.done, state_r == ST_WAIT, "alu result outside wait state")
  `RTBC_ASSERT_IMPL(a_norm_done_in_enc, clk, rst_n, norm_rsp.done, state_r == ST_ENC_WAIT, "encoder result outside its wait state")
  `RTBC_ASSERT_IMPL(a_word_needs_accept, clk, rst_n, out_valid, !out_data.word_valid || out_data.request_accepted, "word valid on a rejected request")
  `RTBC_ASSERT_NEXT(a_check_leaves, clk, rst_n, state_r == ST_CHECK, state_r == ST_ISSUE || state_r == ST_DONE, "bad exit from request check")

endmodule

`default_nettype wire
